[rtl/core/rsmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rsmc_pkg;

    // Channels that may be populated; higher indexes read as not populated
    localparam int CHANNELS = 16;

    // Division pipeline shape: 64 steps for the ohm quotient, 32 for kPa
    localparam int DIV_STAGES = 16;
    localparam int A_STEPS    = 4;
    localparam int B_STEPS    = 2;

    // Cycles from accepted item to done strobe
    localparam int LATENCY = 25;

    // Register reset values
    localparam logic [19:0] REF_RES_RESET = 20'd10000;

    // Front-end constants
    localparam logic signed [16:0] MIN_HEAD    = 17'sd5;      // minimum source headroom
    localparam logic signed [16:0] TEMP_OFFSET = 17'sd8192;   // 32 F in Q8.8
    localparam logic [16:0]        CLAMP_K     = 17'd75000;   // 75 kOhm * 1000 per count of d

    // Watermark denominator: 2304e9*d - 87597*2^8*p - 3765625*2^4*(t*d)
    localparam logic [24:0] C_T1     = 25'd17578125;  // times 2^17
    localparam int          C_T1_SH  = 17;
    localparam logic [16:0] C_T2     = 17'd87597;     // times 2^8
    localparam int          C_T2_SH  = 8;
    localparam logic [21:0] C_T3     = 22'd3765625;   // times 2^4
    localparam int          C_T3_SH  = 4;

    // Watermark numerator: 4093000*d + 3213*p, then times 9000*2^24
    localparam logic [21:0] C_A0 = 22'd4093000;
    localparam logic [11:0] C_A1 = 12'd3213;
    localparam logic [13:0] C_K  = 14'd9000;

    typedef enum logic [1:0] {
        TYPE_NONE   = 2'd0,
        TYPE_RES    = 2'd1,
        TYPE_WMARK  = 2'd2,
        TYPE_UNUSED = 2'd3
    } sensor_type_t;

    typedef enum logic {
        REG_REF_RES      = 1'b0,
        REG_SENSOR_TYPES = 1'b1
    } reg_sel_t;

    typedef struct packed {
        logic [3:0]         channel;
        logic [15:0]        channel_voltage;
        logic [15:0]        sink_voltage;
        logic [15:0]        source_voltage;
        logic signed [15:0] soil_temp_f;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] resistance_ohms;
        logic signed [31:0] reading;
        logic               reading_saturated;
    } result_t;

    typedef struct packed {
        sensor_type_t typ;
        logic         p_neg;
        logic         a_neg;
        logic         m_bad;
        logic         b_ovf;
    } rsmc_side_t;

    // One item in flight through the divider pipeline
    typedef struct packed {
        logic [63:0] qa;      // ohm dividend shifting out, quotient shifting in
        logic [15:0] rem_a;
        logic [15:0] d;
        logic [31:0] qb;      // kPa low dividend bits out, quotient in
        logic [61:0] rem_b;
        logic [61:0] m;
        rsmc_side_t  side;
    } rsmc_div_t;

    // Restoring division steps for one pipeline stage
    function automatic rsmc_div_t div_step(input rsmc_div_t x);
        rsmc_div_t   y;
        logic [16:0] ra;
        logic [62:0] rb;
        y = x;
        for (int i = 0; i < A_STEPS; i++)
        begin
            ra = {y.rem_a, y.qa[63]};
            y.qa = {y.qa[62:0], 1'b0};
            if (ra >= {1'b0, y.d})
            begin
                ra = ra - {1'b0, y.d};
                y.qa[0] = 1'b1;
            end
            y.rem_a = ra[15:0];
        end
        for (int j = 0; j < B_STEPS; j++)
        begin
            rb = {y.rem_b, y.qb[31]};
            y.qb = {y.qb[30:0], 1'b0};
            if (rb >= {1'b0, y.m})
            begin
                rb = rb - {1'b0, y.m};
                y.qb[0] = 1'b1;
            end
            y.rem_b = rb[61:0];
        end
        return y;
    endfunction

    // Apply sign to a magnitude and saturate to 32 bits; bit 32 is the flag
    function automatic logic [32:0] sat_signed(input logic [63:0] mag, input logic neg);
        logic [32:0] r;
        if (neg)
        begin
            if (mag > 64'h0000_0000_8000_0000)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, (~mag[31:0]) + 32'd1};
        end
        else
        begin
            if (mag > 64'h0000_0000_7FFF_FFFF)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, mag[31:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/rsmc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: both quotients advance a few bits per stage
module rsmc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rsmc_pkg::rsmc_div_t in_data,
    output logic               out_valid,
    output rsmc_pkg::rsmc_div_t out_data
);

    rsmc_pkg::rsmc_div_t stage_src  [rsmc_pkg::DIV_STAGES];
    rsmc_pkg::rsmc_div_t stage_next [rsmc_pkg::DIV_STAGES];
    rsmc_pkg::rsmc_div_t stage_reg  [rsmc_pkg::DIV_STAGES];
    logic [rsmc_pkg::DIV_STAGES-1:0] valid_reg;

    assign stage_src[0] = in_data;

    genvar g;
    generate
        for (g = 0; g < rsmc_pkg::DIV_STAGES; g++)
        begin : g_stage
            if (g > 0)
            begin : g_link
                assign stage_src[g] = stage_reg[g-1];
            end
            assign stage_next[g] = rsmc_pkg::div_step(stage_src[g]);

            always_ff @(posedge clk)
            begin
                stage_reg[g] <= stage_next[g];
            end
        end
    endgenerate

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[rsmc_pkg::DIV_STAGES-2:0], in_valid};
    end

    assign out_valid = valid_reg[rsmc_pkg::DIV_STAGES-1];
    assign out_data  = stage_reg[rsmc_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/core/resistive_soil_moisture_convert.sv]
`timescale 1ns / 1ps
`default_nettype none

// Soil sensor conversion. Takes one item per clock (busy is always low) and
// returns one result per item, in order, on a single-cycle done strobe that
// cannot be held off. The path runs through the divider pipeline: 16 stages
// that each retire 4 bits of the 64-bit ohm quotient and 2 bits of the 32-bit
// kPa quotient, behind 8 stages of differences, constant multiplies and
// denominator assembly, plus the output register. Registers sit on an APB
// port: reference resistance at 0x0, sensor types at 0x4; write them only
// while no item is in flight.
module resistive_soil_moisture_convert (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rsmc_pkg::in_item_t  item,
    output logic                done,
    output rsmc_pkg::result_t   result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [19:0]        ref_res_reg;
    logic [31:0]        types_reg;
    rsmc_pkg::reg_sel_t reg_sel;
    logic               cfg_wr;

    assign reg_sel = rsmc_pkg::reg_sel_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_res_reg <= rsmc_pkg::REF_RES_RESET;
            types_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                rsmc_pkg::REG_REF_RES:      ref_res_reg <= pwdata[19:0];
                rsmc_pkg::REG_SENSOR_TYPES: types_reg   <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            rsmc_pkg::REG_REF_RES:      prdata = {12'd0, ref_res_reg};
            rsmc_pkg::REG_SENSOR_TYPES: prdata = types_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: every start is taken
    // ------------------------------------------------------------------
    logic       accept;
    logic [7:0] vld_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[6:0], accept};
    end

    // ------------------------------------------------------------------
    // S1: headroom, channel-sink difference, temperature offset, type
    // ------------------------------------------------------------------
    logic signed [16:0]     head;
    logic [31:0]            types_shift;
    rsmc_pkg::sensor_type_t typ_next;

    logic signed [16:0]     vs1_reg;
    logic signed [16:0]     t1_reg;
    logic [15:0]            d1_reg;
    rsmc_pkg::sensor_type_t typ1_reg;

    assign head = $signed({1'b0, item.source_voltage}) - $signed({1'b0, item.channel_voltage});
    assign types_shift = types_reg >> {item.channel, 1'b0};
    assign typ_next = ({1'b0, item.channel} < 5'(rsmc_pkg::CHANNELS))
                    ? rsmc_pkg::sensor_type_t'(types_shift[1:0]) : rsmc_pkg::TYPE_NONE;

    always_ff @(posedge clk)
    begin
        vs1_reg  <= $signed({1'b0, item.channel_voltage}) - $signed({1'b0, item.sink_voltage});
        t1_reg   <= $signed({item.soil_temp_f[15], item.soil_temp_f}) - rsmc_pkg::TEMP_OFFSET;
        d1_reg   <= (head < rsmc_pkg::MIN_HEAD) ? rsmc_pkg::MIN_HEAD[15:0] : head[15:0];
        typ1_reg <= typ_next;
    end

    // ------------------------------------------------------------------
    // S2: p = (v - sink) * Rref, t*d, clamp limit 75000*d
    // ------------------------------------------------------------------
    logic signed [37:0]     p2_reg;
    logic signed [33:0]     td2_reg;
    logic [32:0]            lim2_reg;
    logic [15:0]            d2_reg;
    rsmc_pkg::sensor_type_t typ2_reg;

    always_ff @(posedge clk)
    begin
        p2_reg   <= vs1_reg * $signed({1'b0, ref_res_reg});
        td2_reg  <= t1_reg * $signed({1'b0, d1_reg});
        lim2_reg <= d1_reg * rsmc_pkg::CLAMP_K;
        d2_reg   <= d1_reg;
        typ2_reg <= typ1_reg;
    end

    // ------------------------------------------------------------------
    // S3: clamp p for kPa, magnitude of p for the ohm divider
    // ------------------------------------------------------------------
    logic signed [37:0]     lim_s;
    logic signed [37:0]     pc3_reg;
    logic [36:0]            pmag3_reg;
    logic                   pneg3_reg;
    logic signed [33:0]     td3_reg;
    logic [15:0]            d3_reg;
    rsmc_pkg::sensor_type_t typ3_reg;

    assign lim_s = $signed({5'd0, lim2_reg});

    always_ff @(posedge clk)
    begin
        pc3_reg   <= (p2_reg > lim_s) ? lim_s : p2_reg;
        pmag3_reg <= 37'(p2_reg[37] ? -p2_reg : p2_reg);
        pneg3_reg <= p2_reg[37];
        td3_reg   <= td2_reg;
        d3_reg    <= d2_reg;
        typ3_reg  <= typ2_reg;
    end

    // ------------------------------------------------------------------
    // S4: constant products of the kPa numerator and denominator
    // ------------------------------------------------------------------
    logic [40:0]            t1p4_reg;
    logic signed [55:0]     t2p4_reg;
    logic signed [56:0]     t3p4_reg;
    logic [37:0]            a0p4_reg;
    logic signed [50:0]     a1p4_reg;
    logic [36:0]            pmag4_reg;
    logic                   pneg4_reg;
    logic [15:0]            d4_reg;
    rsmc_pkg::sensor_type_t typ4_reg;

    always_ff @(posedge clk)
    begin
        t1p4_reg  <= d3_reg * rsmc_pkg::C_T1;
        t2p4_reg  <= pc3_reg * $signed({1'b0, rsmc_pkg::C_T2});
        t3p4_reg  <= td3_reg * $signed({1'b0, rsmc_pkg::C_T3});
        a0p4_reg  <= d3_reg * rsmc_pkg::C_A0;
        a1p4_reg  <= pc3_reg * $signed({1'b0, rsmc_pkg::C_A1});
        pmag4_reg <= pmag3_reg;
        pneg4_reg <= pneg3_reg;
        d4_reg    <= d3_reg;
        typ4_reg  <= typ3_reg;
    end

    // ------------------------------------------------------------------
    // S5: denominator m and numerator a
    // ------------------------------------------------------------------
    logic signed [63:0]     m5_reg;
    logic signed [50:0]     a5_reg;
    logic [36:0]            pmag5_reg;
    logic                   pneg5_reg;
    logic [15:0]            d5_reg;
    rsmc_pkg::sensor_type_t typ5_reg;

    always_ff @(posedge clk)
    begin
        m5_reg    <= $signed({6'd0, t1p4_reg, 17'd0})
                   - (64'(t2p4_reg) <<< rsmc_pkg::C_T2_SH)
                   - (64'(t3p4_reg) <<< rsmc_pkg::C_T3_SH);
        a5_reg    <= $signed({13'd0, a0p4_reg}) + a1p4_reg;
        pmag5_reg <= pmag4_reg;
        pneg5_reg <= pneg4_reg;
        d5_reg    <= d4_reg;
        typ5_reg  <= typ4_reg;
    end

    // ------------------------------------------------------------------
    // S6: sign handling of a and m
    // ------------------------------------------------------------------
    logic [49:0]            amag6_reg;
    logic                   aneg6_reg;
    logic [61:0]            m6_reg;
    logic                   mbad6_reg;
    logic [36:0]            pmag6_reg;
    logic                   pneg6_reg;
    logic [15:0]            d6_reg;
    rsmc_pkg::sensor_type_t typ6_reg;

    always_ff @(posedge clk)
    begin
        amag6_reg <= 50'(a5_reg[50] ? -a5_reg : a5_reg);
        aneg6_reg <= a5_reg[50];
        m6_reg    <= m5_reg[61:0];
        mbad6_reg <= m5_reg[63] || (m5_reg == '0);
        pmag6_reg <= pmag5_reg;
        pneg6_reg <= pneg5_reg;
        d6_reg    <= d5_reg;
        typ6_reg  <= typ5_reg;
    end

    // ------------------------------------------------------------------
    // S7: scale |a| by 9000 (the 2^24 part is a shift)
    // ------------------------------------------------------------------
    logic [63:0]            ab7_reg;
    logic                   aneg7_reg;
    logic [61:0]            m7_reg;
    logic                   mbad7_reg;
    logic [36:0]            pmag7_reg;
    logic                   pneg7_reg;
    logic [15:0]            d7_reg;
    rsmc_pkg::sensor_type_t typ7_reg;

    always_ff @(posedge clk)
    begin
        ab7_reg   <= amag6_reg * rsmc_pkg::C_K;
        aneg7_reg <= aneg6_reg;
        m7_reg    <= m6_reg;
        mbad7_reg <= mbad6_reg;
        pmag7_reg <= pmag6_reg;
        pneg7_reg <= pneg6_reg;
        d7_reg    <= d6_reg;
        typ7_reg  <= typ6_reg;
    end

    // ------------------------------------------------------------------
    // S8: divider setup; upper dividend half >= m means quotient >= 2^32
    // ------------------------------------------------------------------
    logic [55:0]         r0;
    logic                b_ovf;
    rsmc_pkg::rsmc_div_t div_next;
    rsmc_pkg::rsmc_div_t div_in_reg;

    assign r0    = ab7_reg[63:8];
    assign b_ovf = {7'd0, r0} >= {1'b0, m7_reg};

    always_comb
    begin
        div_next.qa         = {11'd0, pmag7_reg, 16'd0};
        div_next.rem_a      = '0;
        div_next.d          = d7_reg;
        div_next.qb         = {ab7_reg[7:0], 24'd0};
        div_next.rem_b      = b_ovf ? 62'd0 : {6'd0, r0};
        div_next.m          = m7_reg;
        div_next.side.typ   = typ7_reg;
        div_next.side.p_neg = pneg7_reg;
        div_next.side.a_neg = aneg7_reg;
        div_next.side.m_bad = mbad7_reg;
        div_next.side.b_ovf = b_ovf;
    end

    always_ff @(posedge clk)
    begin
        div_in_reg <= div_next;
    end

    // ------------------------------------------------------------------
    // Division pipeline
    // ------------------------------------------------------------------
    logic                div_valid;
    rsmc_pkg::rsmc_div_t div_out;

    rsmc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[7]),
        .in_data   (div_in_reg),
        .out_valid (div_valid),
        .out_data  (div_out)
    );

    // ------------------------------------------------------------------
    // Output: sign, saturation and type select
    // ------------------------------------------------------------------
    logic [32:0]       ohm_sat;
    logic [32:0]       qa_sat;
    logic [32:0]       qb_sat;
    rsmc_pkg::result_t res_next;
    rsmc_pkg::result_t result_reg;
    logic              done_reg;

    assign ohm_sat = rsmc_pkg::sat_signed({16'd0, div_out.qa[63:16]}, div_out.side.p_neg);
    assign qa_sat  = rsmc_pkg::sat_signed(div_out.qa, div_out.side.p_neg);
    assign qb_sat  = rsmc_pkg::sat_signed({32'd0, div_out.qb}, div_out.side.a_neg);

    always_comb
    begin
        res_next.resistance_ohms   = $signed(ohm_sat[31:0]);
        res_next.reading           = '0;
        res_next.reading_saturated = 1'b0;
        case (div_out.side.typ)
            rsmc_pkg::TYPE_NONE:
            begin
                res_next.resistance_ohms = '0;
            end
            rsmc_pkg::TYPE_RES:
            begin
                res_next.reading           = $signed(qa_sat[31:0]);
                res_next.reading_saturated = qa_sat[32];
            end
            rsmc_pkg::TYPE_WMARK:
            begin
                if (div_out.side.m_bad)
                begin
                    // denominator not positive
                    res_next.reading           = 32'sh7FFF_FFFF;
                    res_next.reading_saturated = 1'b1;
                end
                else if (div_out.side.b_ovf)
                begin
                    res_next.reading = div_out.side.a_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    res_next.reading_saturated = 1'b1;
                end
                else
                begin
                    res_next.reading           = $signed(qb_sat[31:0]);
                    res_next.reading_saturated = qb_sat[32];
                end
            end
            rsmc_pkg::TYPE_UNUSED:
            begin
                res_next.reading = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/core/rsmc_check.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the converter
module rsmc_check (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input rsmc_pkg::result_t result,
    input logic              pready
);

    // Every accepted item gives a result a fixed latency later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(rsmc_pkg::LATENCY) done)
        else $error("missing result after accepted item");

    // No result without an item accepted at the matching time
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, rsmc_pkg::LATENCY))
        else $error("result without accepted item");

    // Flagged readings sit at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.reading_saturated) |->
            (result.reading == 32'sh7FFF_FFFF || result.reading == 32'sh8000_0000))
        else $error("saturation flag with reading off the rails");

    // Input side never stalls
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    // Register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind resistive_soil_moisture_convert rsmc_check u_rsmc_check (.*);

`default_nettype wire
